// ===== hdl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check that is switched off while reset is high
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also holds across reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/tgc_pkg.sv =====
// ---------------------------------------------------------------------------
// tgc_pkg
// Types and constants shared by the touch gesture classifier files.
// ---------------------------------------------------------------------------
package tgc_pkg;

   // counter width default and threshold register width
   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int CFG_WIDTH           = 16;
   localparam int CSR_INDEX_WIDTH     = 2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FADE_MS     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_MS     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_MS     = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COOLDOWN_MS = 2'd3;

   // register reset values
   localparam logic [CFG_WIDTH-1:0] FADE_MS_RESET     = 16'd75;
   localparam logic [CFG_WIDTH-1:0] LONG_MS_RESET     = 16'd2000;
   localparam logic [CFG_WIDTH-1:0] HOLD_MS_RESET     = 16'd5000;
   localparam logic [CFG_WIDTH-1:0] COOLDOWN_MS_RESET = 16'd300;

   // request payload
   typedef struct packed {
      logic sensor_hit;
      logic rearm_defer;
   } req_data_type;

   // response payload
   typedef struct packed {
      logic press_start;
      logic long_press;
      logic hold_press;
      logic press_release;
      logic cooldown_done;
      logic touch_active;
   } rsp_data_type;

   // threshold registers
   typedef struct packed {
      logic [CFG_WIDTH-1:0] fade_ms;
      logic [CFG_WIDTH-1:0] long_ms;
      logic [CFG_WIDTH-1:0] hold_ms;
      logic [CFG_WIDTH-1:0] cooldown_ms;
   } tgc_cfg_type;

   // touch tracking flags
   typedef struct packed {
      logic active_flag;
      logic cooling_flag;
      logic down_reported;
      logic long_reported;
      logic hold_reported;
   } tgc_flags_type;

endpackage

// ===== hdl/tgc_step.sv =====
// ---------------------------------------------------------------------------
// tgc_step
// Next-state and event logic for one millisecond tick of the classifier.
// ---------------------------------------------------------------------------
module tgc_step
   import tgc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  req_data_type            req,
   input  tgc_cfg_type             cfg,
   input  tgc_flags_type           flags,
   input  logic [COUNT_WIDTH-1:0]  duration_count,
   input  logic [COUNT_WIDTH-1:0]  quiet_count,
   input  logic [COUNT_WIDTH-1:0]  cooldown_count,
   output tgc_flags_type           flags_next,
   output logic [COUNT_WIDTH-1:0]  duration_next,
   output logic [COUNT_WIDTH-1:0]  quiet_next,
   output logic [COUNT_WIDTH-1:0]  cooldown_next,
   output rsp_data_type            rsp
);

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam int CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

   logic [COUNT_WIDTH-1:0] dur_inc;
   logic [COUNT_WIDTH-1:0] quiet_inc;
   logic [COUNT_WIDTH-1:0] cd_inc;
   logic                   cooling_arm;
   logic                   start;
   logic                   active_now;
   logic                   long_hit;
   logic                   hold_hit;
   logic                   fade_hit;
   logic                   cd_hit;

   // saturating counter advance
   assign quiet_inc = (quiet_count == CNT_MAX) ? quiet_count
                                               : quiet_count + COUNT_WIDTH'(1);
   assign dur_inc   = (!flags.active_flag || duration_count == CNT_MAX) ? duration_count
                                               : duration_count + COUNT_WIDTH'(1);
   assign cd_inc    = (!flags.cooling_flag || cooldown_count == CNT_MAX) ? cooldown_count
                                               : cooldown_count + COUNT_WIDTH'(1);

   // re-arm request and touch start
   assign cooling_arm = flags.cooling_flag | req.rearm_defer;
   assign start       = req.sensor_hit & ~flags.active_flag & ~cooling_arm;
   assign active_now  = flags.active_flag | start;

   // threshold compares on the updated counters
   always_comb begin
      logic [COUNT_WIDTH-1:0] dur_cur;
      logic [COUNT_WIDTH-1:0] quiet_cur;
      logic [COUNT_WIDTH-1:0] cd_cur;
      dur_cur   = start ? '0 : dur_inc;
      quiet_cur = req.sensor_hit ? '0 : quiet_inc;
      cd_cur    = req.rearm_defer ? '0 : cd_inc;
      long_hit  = CMP_WIDTH'(dur_cur) > CMP_WIDTH'(cfg.long_ms);
      hold_hit  = CMP_WIDTH'(dur_cur) > CMP_WIDTH'(cfg.hold_ms);
      fade_hit  = CMP_WIDTH'(quiet_cur) > CMP_WIDTH'(cfg.fade_ms);
      cd_hit    = CMP_WIDTH'(cd_cur) > CMP_WIDTH'(cfg.cooldown_ms);
      duration_next = dur_cur;
      quiet_next    = quiet_cur;
      // a release starts a fresh cooldown
      cooldown_next = (active_now && fade_hit) ? '0 : cd_cur;
   end

   // events and flag update
   always_comb begin
      rsp        = '0;
      flags_next = flags;
      flags_next.cooling_flag = cooling_arm;
      flags_next.active_flag  = active_now;
      if (active_now) begin
         rsp.press_start = ~flags.down_reported;
         rsp.long_press  = ~flags.long_reported & long_hit;
         rsp.hold_press  = ~flags.hold_reported & hold_hit;
         flags_next.down_reported = 1'b1;
         flags_next.long_reported = flags.long_reported | long_hit;
         flags_next.hold_reported = flags.hold_reported | hold_hit;
         if (fade_hit) begin
            rsp.press_release        = 1'b1;
            flags_next.active_flag   = 1'b0;
            flags_next.cooling_flag  = 1'b1;
            flags_next.down_reported = 1'b0;
            flags_next.long_reported = 1'b0;
            flags_next.hold_reported = 1'b0;
         end
      end else if (cooling_arm && cd_hit) begin
         rsp.cooldown_done       = 1'b1;
         flags_next.cooling_flag = 1'b0;
      end
      rsp.touch_active = flags_next.active_flag;
   end

endmodule

// ===== hdl/touch_gesture_classifier_unit.sv =====
// ---------------------------------------------------------------------------
// touch_gesture_classifier_unit
// Touch press, long press and hold detector driven by millisecond ticks.
// ---------------------------------------------------------------------------
// Usage:
//   Each request on req_* is one millisecond tick carrying sensor_hit and
//   rearm_defer. Every request gives exactly one response on rsp_* with the
//   press_start, long_press, hold_press, press_release and cooldown_done
//   pulses and the touch_active level after that tick.
//   Thresholds are written through csr_wr_en, csr_index and csr_wdata while
//   no request is in flight; index 0 fade, 1 long, 2 hold, 3 cooldown.
//   A request is captured in the input register, then the tick logic updates
//   the state and loads the response register.
//   Throughput is one request per cycle while rsp_ready stays high, set by the
//   state update loop through the counters and flags.
//   When the receiver stalls the response register holds its value; the
//   input register fills, then req_ready drops until rsp_ready returns.
//   Reset clears both stages, the state and loads default thresholds
//   (fade 75, long 2000, hold 5000, cooldown 300).
// ---------------------------------------------------------------------------
module touch_gesture_classifier_unit
   import tgc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_data_type               req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_data_type               rsp_data,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_wdata
);

   tgc_cfg_type             cfg_ff;
   logic                    in_valid_ff;
   req_data_type            in_data_ff;
   logic                    out_valid_ff;
   rsp_data_type            out_data_ff;
   tgc_flags_type           flags_ff;
   tgc_flags_type           flags_in;
   logic [COUNT_WIDTH-1:0]  duration_ff;
   logic [COUNT_WIDTH-1:0]  duration_in;
   logic [COUNT_WIDTH-1:0]  quiet_ff;
   logic [COUNT_WIDTH-1:0]  quiet_in;
   logic [COUNT_WIDTH-1:0]  cooldown_ff;
   logic [COUNT_WIDTH-1:0]  cooldown_in;
   rsp_data_type            out_data_in;
   logic                    advance;

   // stage handshakes
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fade_ms     <= FADE_MS_RESET;
         cfg_ff.long_ms     <= LONG_MS_RESET;
         cfg_ff.hold_ms     <= HOLD_MS_RESET;
         cfg_ff.cooldown_ms <= COOLDOWN_MS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FADE_MS:     cfg_ff.fade_ms     <= csr_wdata;
            CSR_LONG_MS:     cfg_ff.long_ms     <= csr_wdata;
            CSR_HOLD_MS:     cfg_ff.hold_ms     <= csr_wdata;
            CSR_COOLDOWN_MS: cfg_ff.cooldown_ms <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // tick logic
   tgc_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_tgc_step (
      .req            (in_data_ff),
      .cfg            (cfg_ff),
      .flags          (flags_ff),
      .duration_count (duration_ff),
      .quiet_count    (quiet_ff),
      .cooldown_count (cooldown_ff),
      .flags_next     (flags_in),
      .duration_next  (duration_in),
      .quiet_next     (quiet_in),
      .cooldown_next  (cooldown_in),
      .rsp            (out_data_in)
   );

   // touch state, updated once per request
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff    <= '0;
         duration_ff <= '0;
         quiet_ff    <= '0;
         cooldown_ff <= '0;
      end else if (advance) begin
         flags_ff    <= flags_in;
         duration_ff <= duration_in;
         quiet_ff    <= quiet_in;
         cooldown_ff <= cooldown_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

// ===== hdl/tgc_checker.sv =====
// ---------------------------------------------------------------------------
// tgc_checker
// Port-level checks on the classifier response channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tgc_checker
   import tgc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_data_type rsp_data
);

   // nothing is offered straight after reset
   `ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_valid, "response after reset")

   // a stalled response holds
   `ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled response changed")

   // press events only come with an active touch or with its release
   `ASSERT_RST(a_press_active, clock, reset, rsp_valid && (rsp_data.press_start || rsp_data.long_press || rsp_data.hold_press) |-> rsp_data.touch_active || rsp_data.press_release, "press event without active touch")

   // release and re-arm leave the touch inactive
   `ASSERT_RST(a_release_idle, clock, reset, rsp_valid && (rsp_data.press_release || rsp_data.cooldown_done) |-> !rsp_data.touch_active, "release event with active touch")

   // a touch cannot start and end in one tick
   `ASSERT_RST(a_down_up_excl, clock, reset, rsp_valid |-> !(rsp_data.press_start && rsp_data.press_release), "touch start and release together")

endmodule

bind touch_gesture_classifier_unit tgc_checker u_tgc_checker (.*);
